FILE: rtl/core/body_envelope_framer_assert.svh
// Assertion macros shared by the body envelope framer RTL
`ifndef BODY_ENVELOPE_FRAMER_ASSERT_SVH
`define BODY_ENVELOPE_FRAMER_ASSERT_SVH

// Plain property, checked on every clock outside reset
`define BEF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("%m: check failed");

// Same-cycle implication
`define BEF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication
`define BEF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

FILE: rtl/core/bef_pkg.sv
// Package: constants, types and helpers of the body envelope framer
`default_nettype none

package bef_pkg;

    localparam int MAX_LEN_BITS = 16;
    localparam int CNT_W        = MAX_LEN_BITS;
    localparam int OFF_W        = 16;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;

    // Last index into "<body" during the name match
    localparam logic [2:0] OPEN_LAST_IDX = 3'd4;

    typedef enum logic [6:0] {
        PH_LEAD  = 7'b0000001,
        PH_MATCH = 7'b0000010,
        PH_DELIM = 7'b0000100,
        PH_SCAN  = 7'b0001000,
        PH_SLASH = 7'b0010000,
        PH_OPEN  = 7'b0100000,
        PH_SELF  = 7'b1000000
    } phase_t;

    typedef enum logic [9:0] {
        TL_IDLE  = 10'b0000000001,
        TL_M1    = 10'b0000000010,
        TL_M2    = 10'b0000000100,
        TL_M3    = 10'b0000001000,
        TL_M4    = 10'b0000010000,
        TL_M5    = 10'b0000100000,
        TL_NAME6 = 10'b0001000000,
        TL_WS1   = 10'b0010000000,
        TL_GT    = 10'b0100000000,
        TL_WS2   = 10'b1000000000
    } tail_t;

    // Start tag parser view after the current byte
    typedef struct packed {
        logic             failed;
        logic             closing_seen;
        logic             is_open;
        logic             is_self;
        logic [CNT_W-1:0] tag_end;
    } phase_stat_t;

    // Closing tag matcher view after the current byte
    typedef struct packed {
        logic             closed_ok;
        logic [CNT_W-1:0] tag_pos;
    } tail_stat_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    // Expected byte of "<body" at index 1..4
    function automatic logic [7:0] open_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd1:    ch = CH_B;
            3'd2:    ch = CH_O;
            3'd3:    ch = CH_D;
            3'd4:    ch = CH_Y;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bef_tail.sv
// Closing tag matcher: tracks "</body" ws* ">" ws* at the end of the message
`default_nettype none

module bef_tail (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    last,
    input  wire logic [7:0]              data,
    input  wire logic [bef_pkg::CNT_W-1:0] pos,
    output bef_pkg::tail_stat_t          stat
);

    bef_pkg::tail_t                tail_reg, tail_next;
    logic [bef_pkg::CNT_W-1:0]     pos_reg, pos_next;

    always_comb begin
        tail_next = tail_reg;
        pos_next  = pos_reg;
        if (data == bef_pkg::CH_LT) begin
            // a '<' always restarts the match
            tail_next = bef_pkg::TL_M1;
            pos_next  = pos;
        end else begin
            case (tail_reg)
                bef_pkg::TL_M1: begin
                    tail_next = (data == bef_pkg::CH_SLASH) ? bef_pkg::TL_M2 : bef_pkg::TL_IDLE;
                end
                bef_pkg::TL_M2: begin
                    tail_next = (data == bef_pkg::CH_B) ? bef_pkg::TL_M3 : bef_pkg::TL_IDLE;
                end
                bef_pkg::TL_M3: begin
                    tail_next = (data == bef_pkg::CH_O) ? bef_pkg::TL_M4 : bef_pkg::TL_IDLE;
                end
                bef_pkg::TL_M4: begin
                    tail_next = (data == bef_pkg::CH_D) ? bef_pkg::TL_M5 : bef_pkg::TL_IDLE;
                end
                bef_pkg::TL_M5: begin
                    tail_next = (data == bef_pkg::CH_Y) ? bef_pkg::TL_NAME6 : bef_pkg::TL_IDLE;
                end
                bef_pkg::TL_NAME6, bef_pkg::TL_WS1: begin
                    if (bef_pkg::is_ws(data)) begin
                        tail_next = bef_pkg::TL_WS1;
                    end else if (data == bef_pkg::CH_GT) begin
                        tail_next = bef_pkg::TL_GT;
                    end else begin
                        tail_next = bef_pkg::TL_IDLE;
                    end
                end
                bef_pkg::TL_GT, bef_pkg::TL_WS2: begin
                    tail_next = bef_pkg::is_ws(data) ? bef_pkg::TL_WS2 : bef_pkg::TL_IDLE;
                end
                default: begin
                    tail_next = bef_pkg::TL_IDLE;
                end
            endcase
        end
    end

    assign stat.closed_ok = (tail_next == bef_pkg::TL_GT) || (tail_next == bef_pkg::TL_WS2);
    assign stat.tag_pos   = pos_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg <= bef_pkg::TL_IDLE;
            pos_reg  <= '0;
        end else if (en) begin
            if (last) begin
                tail_reg <= bef_pkg::TL_IDLE;
                pos_reg  <= '0;
            end else begin
                tail_reg <= tail_next;
                pos_reg  <= pos_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bef_phase.sv
// Start tag parser: leading whitespace, "<body", delimiter, quoted scan, self-closing slash
`default_nettype none

module bef_phase (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      last,
    input  wire logic                      ovf,
    input  wire logic [7:0]                data,
    input  wire logic [bef_pkg::CNT_W-1:0] pos,
    output bef_pkg::phase_stat_t           stat
);

    bef_pkg::phase_t               phase_reg, phase_next;
    logic [2:0]                    idx_reg, idx_next;
    logic                          sq_reg, sq_next;
    logic                          dq_reg, dq_next;
    logic [bef_pkg::CNT_W-1:0]     tag_end_reg, tag_end_next;
    logic                          closing_reg, closing_next;
    logic                          failed_reg, failed_next;
    logic [bef_pkg::CNT_W-1:0]     pos_inc;

    assign pos_inc = pos + bef_pkg::CNT_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        sq_next      = sq_reg;
        dq_next      = dq_reg;
        tag_end_next = tag_end_reg;
        closing_next = closing_reg;
        failed_next  = failed_reg | ovf;
        if (!failed_next) begin
            case (phase_reg)
                bef_pkg::PH_LEAD: begin
                    if (!bef_pkg::is_ws(data)) begin
                        if (data == bef_pkg::CH_LT) begin
                            phase_next = bef_pkg::PH_MATCH;
                            idx_next   = 3'd1;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                end
                bef_pkg::PH_MATCH: begin
                    if (data != bef_pkg::open_char(idx_reg)) begin
                        failed_next = 1'b1;
                    end else if (idx_reg == bef_pkg::OPEN_LAST_IDX) begin
                        phase_next = bef_pkg::PH_DELIM;
                        idx_next   = 3'd0;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                bef_pkg::PH_DELIM: begin
                    if (bef_pkg::is_ws(data)) begin
                        phase_next = bef_pkg::PH_SCAN;
                    end else if (data == bef_pkg::CH_GT) begin
                        phase_next   = bef_pkg::PH_OPEN;
                        tag_end_next = pos_inc;
                        closing_next = 1'b1;
                    end else if (data == bef_pkg::CH_SLASH) begin
                        phase_next = bef_pkg::PH_SLASH;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                bef_pkg::PH_SCAN: begin
                    if (sq_reg) begin
                        if (data == bef_pkg::CH_SQ) sq_next = 1'b0;
                    end else if (dq_reg) begin
                        if (data == bef_pkg::CH_DQ) dq_next = 1'b0;
                    end else if (data == bef_pkg::CH_SQ) begin
                        sq_next = 1'b1;
                    end else if (data == bef_pkg::CH_DQ) begin
                        dq_next = 1'b1;
                    end else if (data == bef_pkg::CH_SLASH) begin
                        phase_next = bef_pkg::PH_SLASH;
                    end else if (data == bef_pkg::CH_GT) begin
                        phase_next   = bef_pkg::PH_OPEN;
                        tag_end_next = pos_inc;
                        closing_next = 1'b1;
                    end
                end
                bef_pkg::PH_SLASH: begin
                    if (data == bef_pkg::CH_GT) begin
                        phase_next   = bef_pkg::PH_SELF;
                        tag_end_next = pos_inc;
                        closing_next = 1'b1;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                default: begin
                    // start tag closed: ignore further bytes
                end
            endcase
        end
    end

    assign stat.failed       = failed_next;
    assign stat.closing_seen = closing_next;
    assign stat.is_open      = (phase_next == bef_pkg::PH_OPEN);
    assign stat.is_self      = (phase_next == bef_pkg::PH_SELF);
    assign stat.tag_end      = tag_end_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= bef_pkg::PH_LEAD;
            idx_reg     <= 3'd0;
            sq_reg      <= 1'b0;
            dq_reg      <= 1'b0;
            tag_end_reg <= '0;
            closing_reg <= 1'b0;
            failed_reg  <= 1'b0;
        end else if (en) begin
            if (last) begin
                phase_reg   <= bef_pkg::PH_LEAD;
                idx_reg     <= 3'd0;
                sq_reg      <= 1'b0;
                dq_reg      <= 1'b0;
                tag_end_reg <= '0;
                closing_reg <= 1'b0;
                failed_reg  <= 1'b0;
            end else begin
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                sq_reg      <= sq_next;
                dq_reg      <= dq_next;
                tag_end_reg <= tag_end_next;
                closing_reg <= closing_next;
                failed_reg  <= failed_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/body_envelope_framer.sv
// Top level of the body envelope framer: input register, parsers, result register
// Flow: an accepted byte waits in the input register until the parse stage takes it;
//   the last byte's result enters the result register, and m_valid, as it leaves.
// Throughput: one byte per cycle; s_ready
//   drops only while a last byte waits for the result register to free up.
// Reset: synchronous, active low aresetn; clears all parser state and both valids.
`default_nettype none

`include "body_envelope_framer_assert.svh"

module body_envelope_framer (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // byte input channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_data_byte,
    input  wire logic                      s_last_byte,
    // result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_found,
    output logic                           m_self_closing,
    output logic [bef_pkg::OFF_W-1:0]      m_start_tag_end,
    output logic [bef_pkg::OFF_W-1:0]      m_content_end
);

    // Input register: holds one accepted transaction for the parse stage
    logic                          in_valid_reg, in_valid_next;
    logic [7:0]                    in_byte_reg;
    logic                          in_last_reg;

    // Byte position within the current message
    logic [bef_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          ovf;

    // Result register
    logic                          m_valid_reg, m_valid_next;
    logic                          found_reg, self_reg;
    logic [bef_pkg::OFF_W-1:0]     start_end_reg, content_end_reg;

    logic                          advance;
    logic                          found_c, self_c;
    logic [bef_pkg::CNT_W-1:0]     s_end_c, c_end_c;

    bef_pkg::phase_stat_t          phase_stat;
    bef_pkg::tail_stat_t           tail_stat;

    // Advance the parse stage unless a last byte would overwrite a waiting result
    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload: capture on every input transaction
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Saturate at the all-ones position; a byte there fails the frame
    assign ovf = (count_reg == {bef_pkg::CNT_W{1'b1}});

    always_comb begin
        count_next = count_reg;
        if (advance) begin
            if (in_last_reg) begin
                count_next = '0;
            end else if (!ovf) begin
                count_next = count_reg + bef_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    bef_phase u_phase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .last    (in_last_reg),
        .ovf     (ovf),
        .data    (in_byte_reg),
        .pos     (count_reg),
        .stat    (phase_stat)
    );

    bef_tail u_tail (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .last    (in_last_reg),
        .data    (in_byte_reg),
        .pos     (count_reg),
        .stat    (tail_stat)
    );

    // Decide the frame from the state as it stands after this byte.
    // An open element needs a complete closing tag that starts at or after
    // the end of the start tag; overlap gives not found.
    always_comb begin
        found_c = 1'b0;
        self_c  = 1'b0;
        s_end_c = '0;
        c_end_c = '0;
        if (!phase_stat.failed && phase_stat.closing_seen) begin
            if (phase_stat.is_self) begin
                found_c = 1'b1;
                self_c  = 1'b1;
                s_end_c = phase_stat.tag_end;
                c_end_c = phase_stat.tag_end;
            end else if (phase_stat.is_open && tail_stat.closed_ok &&
                         (tail_stat.tag_pos >= phase_stat.tag_end)) begin
                found_c = 1'b1;
                s_end_c = phase_stat.tag_end;
                c_end_c = tail_stat.tag_pos;
            end
        end
    end

    // Load the result on the last byte of a message; drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            found_reg       <= found_c;
            self_reg        <= self_c;
            start_end_reg   <= bef_pkg::OFF_W'(s_end_c);
            content_end_reg <= bef_pkg::OFF_W'(c_end_c);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = found_reg;
    assign m_self_closing  = self_reg;
    assign m_start_tag_end = start_end_reg;
    assign m_content_end   = content_end_reg;

    // A new result appears only after a last byte left the parse stage
    `BEF_ASSERT_IMPL(a_result_from_last, $rose(m_valid_reg), $past(advance && in_last_reg))
    // A not-found result carries no flags and zero offsets
    `BEF_ASSERT_IMPL(a_not_found_clean, m_valid_reg && !found_reg,
        !self_reg && (start_end_reg == '0) && (content_end_reg == '0))
    // Input stalls only behind a pending last byte and a blocked result
    `BEF_ASSERT_IMPL(a_stall_reason, !s_ready,
        in_valid_reg && in_last_reg && m_valid_reg && !m_ready)
    // The position restarts from zero after each message
    `BEF_ASSERT_NEXT(a_count_restart, advance && in_last_reg, count_reg == '0)

endmodule

`default_nettype wire
